[src/ubxfb_pkg.sv]
// ----------------------------------------------------------------------------
// ubxfb_pkg
// Shared types and constants of the frame builder: queued command format,
// status codes, register indexes and byte positions within a command.
// ----------------------------------------------------------------------------
package ubxfb_pkg;

   // Status codes carried on every result item
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TOO_LONG = 2'd1;
   localparam logic [1:0] ST_OUTSIDE  = 2'd2;

   // Input item kinds
   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_PAYLOAD = 1'b1;

   // Register indexes
   localparam logic [1:0] CSR_SYNC_FIRST      = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND     = 2'd1;
   localparam logic [1:0] CSR_MAX_PAYLOAD_LEN = 2'd2;

   localparam logic [7:0]  SYNC_FIRST_RST      = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND_RST     = 8'h62;
   localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'd500;

   // Byte positions of a header command
   localparam logic [2:0] STEP_SYNC_1  = 3'd0;
   localparam logic [2:0] STEP_SYNC_2  = 3'd1;
   localparam logic [2:0] STEP_CLASS   = 3'd2;
   localparam logic [2:0] STEP_ID      = 3'd3;
   localparam logic [2:0] STEP_LEN_LO  = 3'd4;
   localparam logic [2:0] STEP_LEN_HI  = 3'd5;
   localparam logic [2:0] STEP_HDR_CKA = 3'd6;
   localparam logic [2:0] STEP_HDR_CKB = 3'd7;

   // Byte positions of a closing payload command
   localparam logic [2:0] STEP_DATA    = 3'd0;
   localparam logic [2:0] STEP_PL_CKA  = 3'd1;
   localparam logic [2:0] STEP_PL_CKB  = 3'd2;

   typedef enum logic [2:0] {
      CMD_HEADER,
      CMD_PAYLOAD,
      CMD_PAYLOAD_LAST,
      CMD_ERR_LONG,
      CMD_ERR_OUTSIDE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         len_zero;
      logic [7:0]   msg_class;
      logic [7:0]   msg_id;
      logic [15:0]  payload_len;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
   } sync_cfg_type;

endpackage

[src/ubxfb_ifs.sv]
// ----------------------------------------------------------------------------
// ubxfb_req_if / ubxfb_rsp_if
// Valid/ready channels of the frame builder: request items in, wire bytes out.
// ----------------------------------------------------------------------------
interface ubxfb_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  msg_class;
   logic [7:0]  msg_id;
   logic [15:0] payload_len;
   logic [7:0]  payload_byte;

   modport source (output valid, func, msg_class, msg_id, payload_len, payload_byte,
                   input ready);
   modport sink   (input valid, func, msg_class, msg_id, payload_len, payload_byte,
                   output ready);
endinterface

interface ubxfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic [1:0] status;

   modport source (output valid, out_byte, frame_end, status, input ready);
   modport sink   (input valid, out_byte, frame_end, status, output ready);
endinterface

[src/ubxfb_front.sv]
// ----------------------------------------------------------------------------
// ubxfb_front
// Accepts request items, tracks the open frame and turns each item into
// one command for the queue.
// ----------------------------------------------------------------------------
module ubxfb_front
   import ubxfb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ubxfb_req_if.sink         req_if,
   input  logic [15:0]       max_payload_len,
   input  logic              push_ready,
   output logic              push_valid,
   output cmd_type           push_cmd
);

   logic        in_frame_ff,   in_frame_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] left_dec;
   logic        take;

   assign req_if.ready = push_ready;
   assign push_valid   = req_if.valid;
   assign take         = req_if.valid && push_ready;
   assign left_dec     = bytes_left_ff - 16'd1;

   always_comb begin
      in_frame_in          = in_frame_ff;
      bytes_left_in        = bytes_left_ff;
      push_cmd.kind        = CMD_ERR_OUTSIDE;
      push_cmd.len_zero    = (req_if.payload_len == 16'd0);
      push_cmd.msg_class   = req_if.msg_class;
      push_cmd.msg_id      = req_if.msg_id;
      push_cmd.payload_len = req_if.payload_len;
      push_cmd.data        = req_if.payload_byte;
      if (req_if.func == FUNC_START) begin
         if (req_if.payload_len > max_payload_len) begin
            push_cmd.kind = CMD_ERR_LONG;
         end else begin
            push_cmd.kind = CMD_HEADER;
            bytes_left_in = req_if.payload_len;
            // a zero-length frame closes right after its header
            in_frame_in   = (req_if.payload_len != 16'd0);
         end
      end else if (in_frame_ff && (bytes_left_ff != 16'd0)) begin
         bytes_left_in = left_dec;
         if (left_dec == 16'd0) begin
            push_cmd.kind = CMD_PAYLOAD_LAST;
            in_frame_in   = 1'b0;
         end else begin
            push_cmd.kind = CMD_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         bytes_left_ff <= 16'd0;
      end else if (take) begin
         in_frame_ff   <= in_frame_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

[src/ubxfb_queue.sv]
// ----------------------------------------------------------------------------
// ubxfb_queue
// Small command FIFO between front and back.
// ----------------------------------------------------------------------------
module ubxfb_queue
   import ubxfb_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop,
   output cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_cmd    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/ubxfb_back.sv]
// ----------------------------------------------------------------------------
// ubxfb_back
// Expands queued commands into wire bytes, one per cycle unless the result
// channel stalls, keeps the running checksum and drives the registered outputs.
// ----------------------------------------------------------------------------
module ubxfb_back
   import ubxfb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sync_cfg_type  sync_cfg,
   input  logic          cmd_valid,
   input  cmd_type       cmd_head,
   output logic          cmd_pop,
   ubxfb_rsp_if.source   rsp_if
);

   cmd_type    cmd_ff,    cmd_in;
   logic       active_ff, active_in;
   logic [2:0] step_ff,   step_in;
   logic [7:0] sum_a_ff,  sum_a_in;
   logic [7:0] sum_b_ff,  sum_b_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       frame_end_ff;
   logic [1:0] status_ff;

   logic       load_ok, emit, last, absorb;
   logic [7:0] byte_sel;
   logic       end_sel;
   logic [1:0] status_sel;
   logic [7:0] sum_a_next;

   assign load_ok = !rsp_valid_ff || rsp_if.ready;
   assign emit    = active_ff && load_ok;

   // byte selection for the current position of the active command
   always_comb begin
      byte_sel   = 8'd0;
      end_sel    = 1'b0;
      status_sel = ST_OK;
      absorb     = 1'b0;
      last       = 1'b1;
      case (cmd_ff.kind)
         CMD_HEADER: begin
            last = cmd_ff.len_zero ? (step_ff == STEP_HDR_CKB) : (step_ff == STEP_LEN_HI);
            case (step_ff)
               STEP_SYNC_1:  byte_sel = sync_cfg.sync_first;
               STEP_SYNC_2:  byte_sel = sync_cfg.sync_second;
               STEP_CLASS: begin
                  byte_sel = cmd_ff.msg_class;
                  absorb   = 1'b1;
               end
               STEP_ID: begin
                  byte_sel = cmd_ff.msg_id;
                  absorb   = 1'b1;
               end
               STEP_LEN_LO: begin
                  byte_sel = cmd_ff.payload_len[7:0];
                  absorb   = 1'b1;
               end
               STEP_LEN_HI: begin
                  byte_sel = cmd_ff.payload_len[15:8];
                  absorb   = 1'b1;
               end
               STEP_HDR_CKA: byte_sel = sum_a_ff;
               STEP_HDR_CKB: begin
                  byte_sel = sum_b_ff;
                  end_sel  = 1'b1;
               end
               default: byte_sel = 8'd0;
            endcase
         end
         CMD_PAYLOAD: begin
            byte_sel = cmd_ff.data;
            absorb   = 1'b1;
         end
         CMD_PAYLOAD_LAST: begin
            last = (step_ff == STEP_PL_CKB);
            case (step_ff)
               STEP_DATA: begin
                  byte_sel = cmd_ff.data;
                  absorb   = 1'b1;
               end
               STEP_PL_CKA: byte_sel = sum_a_ff;
               STEP_PL_CKB: begin
                  byte_sel = sum_b_ff;
                  end_sel  = 1'b1;
               end
               default: byte_sel = 8'd0;
            endcase
         end
         CMD_ERR_LONG:    status_sel = ST_TOO_LONG;
         CMD_ERR_OUTSIDE: status_sel = ST_OUTSIDE;
         default:         status_sel = ST_OUTSIDE;
      endcase
   end

   assign sum_a_next = sum_a_ff + byte_sel;

   always_comb begin
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      if (emit) begin
         if (cmd_ff.kind == CMD_HEADER && step_ff == STEP_SYNC_1) begin
            sum_a_in = 8'd0;
            sum_b_in = 8'd0;
         end else if (absorb) begin
            sum_a_in = sum_a_next;
            sum_b_in = sum_b_ff + sum_a_next;
         end
      end
   end

   // command sequencing: the next command loads on the cycle the last
   // byte of the current one goes out
   always_comb begin
      cmd_pop   = cmd_valid && (!active_ff || (emit && last));
      cmd_in    = cmd_ff;
      active_in = active_ff;
      step_in   = step_ff;
      if (cmd_pop) begin
         cmd_in    = cmd_head;
         active_in = 1'b1;
         step_in   = 3'd0;
      end else if (emit) begin
         if (last) begin
            active_in = 1'b0;
         end
         step_in = 3'(step_ff + 3'd1);
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= 3'd0;
         sum_a_ff     <= 8'd0;
         sum_b_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         out_byte_ff  <= byte_sel;
         frame_end_ff <= end_sel;
         status_ff    <= status_sel;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_byte  = out_byte_ff;
   assign rsp_if.frame_end = frame_end_ff;
   assign rsp_if.status    = status_ff;

endmodule

[src/ubx_frame_builder.sv]
// Path of an accepted item: queue, back end command register, output register.
// Throughput: one output byte per cycle while the receiver is ready (the byte
//   sequencer); payload items at 1 per cycle; a header sends sync to length,
//   plus checksums if empty; closing payload data and checksums; errors a byte.
// Reset (synchronous, active high) empties the queue, closes any open frame,
//   clears both checksums and loads the register reset values.
// ----------------------------------------------------------------------------
// ubx_frame_builder
// Binary command frame encoder with a two-byte Fletcher-style checksum.
// ----------------------------------------------------------------------------
module ubx_frame_builder
   import ubxfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic         clock,
   input  logic         reset,
   ubxfb_req_if.sink    req_if,
   ubxfb_rsp_if.source  rsp_if,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   // Config registers; user must write them only while the block is idle; not enforced
   logic [7:0]  sync_first_ff;
   logic [7:0]  sync_second_ff;
   logic [15:0] max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         max_len_ff     <= MAX_PAYLOAD_LEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYNC_FIRST:      sync_first_ff  <= csr_wdata[7:0];
            CSR_SYNC_SECOND:     sync_second_ff <= csr_wdata[7:0];
            CSR_MAX_PAYLOAD_LEN: max_len_ff     <= csr_wdata;
            default: ;  // no register at this index
         endcase
      end
   end

   sync_cfg_type sync_cfg;
   assign sync_cfg.sync_first  = sync_first_ff;
   assign sync_cfg.sync_second = sync_second_ff;

   // Front: classifies each item against the open frame into one command
   logic    push_valid, push_ready;
   cmd_type push_cmd;

   ubxfb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .max_payload_len (max_len_ff),
      .push_ready      (push_ready),
      .push_valid      (push_valid),
      .push_cmd        (push_cmd)
   );

   // Queue decouples item intake from byte expansion
   logic    pop_valid, pop;
   cmd_type pop_cmd;

   ubxfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   // Back: one wire byte per cycle unless stalled, checksum, registered output item
   ubxfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .sync_cfg  (sync_cfg),
      .cmd_valid (pop_valid),
      .cmd_head  (pop_cmd),
      .cmd_pop   (pop),
      .rsp_if    (rsp_if)
   );

endmodule

[tb/tb_ubx_frame_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ubx_frame_builder
// Self-checking bench for the frame builder. Start and payload items go in on
// the request channel; a local encoder keeps its own checksums, frame state and
// register copy, and predicts every wire byte. Each byte that comes out is
// compared field by field with the oldest prediction. Directed cases come
// first, then random frame traffic under several register settings, with
// random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_ubx_frame_builder;
   import ubxfb_pkg::*;

   localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake on either side
   localparam int SETTLE_CYCLES = 8;     // more than the result latency plus pipeline slack
   localparam int MAX_REPORTS   = 10;

   // One request item, all fields present whatever its kind
   typedef struct packed {
      logic        func;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_len;
      logic [7:0]  payload_byte;
   } frame_req_type;

   // One byte on the wire, as the result channel carries it
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic [1:0] status;
   } wire_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   ubxfb_req_if req_chan();
   ubxfb_rsp_if rsp_chan();

   ubx_frame_builder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Encoder copy: register shadows, running sums, frame progress
   logic [7:0]  sync1_cfg;
   logic [7:0]  sync2_cfg;
   logic [15:0] max_len_cfg;
   logic [7:0]  chk_a;
   logic [7:0]  chk_b;
   logic [15:0] left_in_frame;
   logic        frame_open;

   wire_byte_type bytes_due[$];   // predicted wire bytes, oldest first

   int          mismatch_count = 0;
   int          items_sent     = 0;
   int          stall_cycles   = 0;
   bit          gaps_on        = 1'b1;  // sender idles at random
   bit          stalls_on      = 1'b1;  // receiver stalls at random
   logic [15:0] cur_max_len    = MAX_PAYLOAD_LEN_RST;  // limit the generator honors

   // ------------------------------------------------------------------------
   // Encoder
   // ------------------------------------------------------------------------
   function automatic void queue_byte(input logic [7:0] b, input logic last,
                                      input logic [1:0] st);
      bytes_due.push_back({b, last, st});
   endfunction

   // Byte covered by the checksum: A += byte, B += A, both mod 256
   function automatic void summed_byte(input logic [7:0] b);
      chk_a = chk_a + b;
      chk_b = chk_b + chk_a;
      queue_byte(b, 1'b0, ST_OK);
   endfunction

   function automatic void close_frame();
      queue_byte(chk_a, 1'b0, ST_OK);
      queue_byte(chk_b, 1'b1, ST_OK);
      frame_open = 1'b0;
   endfunction

   function automatic void encode_item(input frame_req_type r);
      if (r.func == FUNC_START) begin
         // Rejected start leaves everything alone, even an open frame
         if (r.payload_len > max_len_cfg) begin
            queue_byte(8'h00, 1'b0, ST_TOO_LONG);
            return;
         end
         // Accepted start drops any frame in progress
         chk_a = 8'h00;
         chk_b = 8'h00;
         queue_byte(sync1_cfg, 1'b0, ST_OK);
         queue_byte(sync2_cfg, 1'b0, ST_OK);
         summed_byte(r.msg_class);
         summed_byte(r.msg_id);
         summed_byte(r.payload_len[7:0]);
         summed_byte(r.payload_len[15:8]);
         left_in_frame = r.payload_len;
         frame_open    = 1'b1;
         if (r.payload_len == 16'd0) close_frame();
      end else if (!frame_open || left_in_frame == 16'd0) begin
         queue_byte(8'h00, 1'b0, ST_OUTSIDE);
      end else begin
         summed_byte(r.payload_byte);
         left_in_frame = left_in_frame - 16'd1;
         if (left_in_frame == 16'd0) close_frame();
      end
   endfunction

   function automatic void flag_mismatch(input string what, input wire_byte_type want,
                                         input wire_byte_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $write("ERROR %0t: %s: expected byte %02h end %0b status %0d, ",
                $realtime, what, want.out_byte, want.frame_end, want.status);
         $display("got byte %02h end %0b status %0d",
                  got.out_byte, got.frame_end, got.status);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: register writes, accepted items and results, all sampled on the
   // same edge so prediction always runs ahead of the byte it explains.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      wire_byte_type got;
      wire_byte_type want;
      if (reset) begin
         sync1_cfg     = SYNC_FIRST_RST;
         sync2_cfg     = SYNC_SECOND_RST;
         max_len_cfg   = MAX_PAYLOAD_LEN_RST;
         chk_a         = 8'h00;
         chk_b         = 8'h00;
         left_in_frame = 16'd0;
         frame_open    = 1'b0;
         bytes_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SYNC_FIRST:      sync1_cfg   = csr_wdata[7:0];
               CSR_SYNC_SECOND:     sync2_cfg   = csr_wdata[7:0];
               CSR_MAX_PAYLOAD_LEN: max_len_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            encode_item({req_chan.func, req_chan.msg_class, req_chan.msg_id,
                         req_chan.payload_len, req_chan.payload_byte});
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.out_byte, rsp_chan.frame_end, rsp_chan.status};
            if (bytes_due.size() == 0) begin
               flag_mismatch("byte with nothing pending", '0, got);
            end else begin
               want = bytes_due.pop_front();
               if (got !== want) flag_mismatch("wire byte mismatch", want, got);
            end
         end
      end
   end

   // Receiver: random back-pressure unless a clean stretch is running
   always @(posedge clock) begin
      if (stalls_on) rsp_chan.ready <= ($urandom_range(99) >= 23);
      else rsp_chan.ready <= 1'b1;
   end

   // Watchdog: a hang shows up as a long run of cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Driver helpers
   // ------------------------------------------------------------------------
   // Unused fields carry random junk; the block must ignore them.
   function automatic frame_req_type make_start(input logic [7:0] cls, input logic [7:0] id,
                                                input logic [15:0] len);
      return {FUNC_START, cls, id, len, 8'($urandom)};
   endfunction

   function automatic frame_req_type make_payload(input logic [7:0] data);
      return {FUNC_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom), data};
   endfunction

   // Valid stays high on return; the next call either keeps it high or drops
   // it for a gap, so it is never lowered and raised in one step.
   task automatic send_item(input frame_req_type r);
      while (gaps_on && $urandom_range(99) < 23) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.func         <= r.func;
      req_chan.msg_class    <= r.msg_class;
      req_chan.msg_id       <= r.msg_id;
      req_chan.payload_len  <= r.payload_len;
      req_chan.payload_byte <= r.payload_byte;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   // Drain everything, then let the pipeline settle. Step past the current edge
   // first, so the monitor has already predicted the item accepted on it.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers back to back; upper data bits of the byte
   // registers carry junk that must be dropped.
   task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [15:0] mx);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_SYNC_FIRST;
      csr_wdata <= {8'($urandom), s1};
      @(posedge clock);
      csr_index <= CSR_SYNC_SECOND;
      csr_wdata <= {8'($urandom), s2};
      @(posedge clock);
      csr_index <= CSR_MAX_PAYLOAD_LEN;
      csr_wdata <= mx;
      @(posedge clock);
      csr_we      <= 1'b0;
      cur_max_len = mx;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset syncs; zero-length frame; all-ones header with wrapping sums
   task automatic test_reset_defaults();
      send_item(make_start(8'h00, 8'h00, 16'd0));
      send_item(make_start(8'hFF, 8'hFF, 16'd2));
      send_item(make_payload(8'hFF));
      send_item(make_payload(8'h00));
   endtask

   // Payload with no frame open, right after a frame closed
   task automatic test_outside_frame();
      send_item(make_payload(8'hFF));
      send_item(make_payload(8'h00));
   endtask

   // Over-limit starts, including one that lands inside an open frame
   task automatic test_too_long();
      send_item(make_start(8'($urandom), 8'($urandom), MAX_PAYLOAD_LEN_RST + 16'd1));
      send_item(make_start(8'h01, 8'h02, 16'hFFFF));
      send_item(make_start(8'h06, 8'h01, 16'd1));
      send_item(make_start(8'h06, 8'h01, MAX_PAYLOAD_LEN_RST + 16'd1));
      send_item(make_payload(8'hA5));   // still closes the open frame
   endtask

   // Register extremes; restart of a long frame; limit boundary
   task automatic test_register_extremes();
      // limit 0: only empty frames pass
      set_config(8'h00, 8'h00, 16'd0);
      send_item(make_start(8'h13, 8'h37, 16'd0));
      send_item(make_start(8'h13, 8'h37, 16'd1));
      send_item(make_payload(8'h42));
      // limit max: open a full-length frame and abandon it with a new start
      set_config(8'hFF, 8'hFF, 16'hFFFF);
      send_item(make_start(8'hAA, 8'h55, 16'hFFFF));
      send_item(make_payload(8'h5A));
      send_item(make_start(8'h0A, 8'h0B, 16'd1));
      send_item(make_payload(8'hFF));
      // length equal to the limit passes, one above fails
      set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, 16'd3);
      send_item(make_start(8'h0B, 8'h09, 16'd3));
      repeat (3) send_item(make_payload(8'($urandom)));
      send_item(make_start(8'h0B, 8'h09, 16'd4));
   endtask

   // Mostly complete frames with random content; some stray payload,
   // over-limit starts and frames cut short by a new start.
   task automatic test_random_frames(input int n_items, input logic [15:0] mx);
      int stop_at;
      int len;
      int cut;
      int pick;
      set_config(8'($urandom), 8'($urandom), mx);
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_item(make_payload(8'($urandom)));
         end else if (pick < 16 && cur_max_len != 16'hFFFF) begin
            send_item(make_start(8'($urandom), 8'($urandom),
                                 16'($urandom_range(65535, int'(cur_max_len) + 1))));
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
            if (len > int'(cur_max_len)) len = cur_max_len;
            cut = len;
            if (len > 1 && $urandom_range(99) < 12) cut = $urandom_range(len - 1, 0);
            send_item(make_start(8'($urandom), 8'($urandom), 16'(len)));
            repeat (cut) send_item(make_payload(8'($urandom)));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= CSR_SYNC_FIRST;
      csr_wdata             <= 16'h0000;
      req_chan.valid        <= 1'b0;
      req_chan.func         <= FUNC_START;
      req_chan.msg_class    <= 8'h00;
      req_chan.msg_id       <= 8'h00;
      req_chan.payload_len  <= 16'h0000;
      req_chan.payload_byte <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_outside_frame();
      test_too_long();
      test_register_extremes();

      test_random_frames(35, 16'($urandom_range(40, 8)));
      // clean stretch: no gaps, no stalls
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      test_random_frames(20, 16'($urandom_range(20, 1)));
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      test_random_frames(15, 16'hFFFF);

      wait_idle();
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
src/ubxfb_pkg.sv
src/ubxfb_ifs.sv
src/ubxfb_front.sv
src/ubxfb_queue.sv
src/ubxfb_back.sv
src/ubx_frame_builder.sv
tb/tb_ubx_frame_builder.sv
